// ===== rtl/epc_pkg.sv =====
// ----------------------------------------------------------------------------
// epc_pkg: shared types and constants of the pattern occurrence counter
// Item layouts of both channels, the command codes and the control group
// that the top level hands to every cell of the compare chain.
// ----------------------------------------------------------------------------
package epc_pkg;

  localparam int BYTE_W    = 8;
  localparam int PIDX_W    = 5;
  localparam int LEN_W     = 6;
  localparam int COUNT_W   = 32;
  localparam int LEN_MIN   = 2;
  localparam int LEN_RESET = 2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEXT = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] byte_value;
    logic [PIDX_W-1:0] pattern_index;
    logic              last_text_byte;
  } epc_in_t;

  typedef struct packed {
    logic               match_here;
    logic [COUNT_W-1:0] match_count;
    logic               final_count;
  } epc_out_t;

  // Control group broadcast to all cells.
  typedef struct packed {
    logic shift_txt;  // a text item shifts into the window
    logic clr;        // the previous text ended: restart the fill
    logic shift_pat;  // realignment shifts one pattern byte in
    logic ld;         // a pattern byte is loaded
    logic cap;        // capture the compare result of the window
  } epc_cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_ALIGN
  } epc_state_t;

endpackage

// ===== rtl/epc_cell.sv =====
// ----------------------------------------------------------------------------
// epc_cell: one position of the compare chain
// Holds one window byte with its fill bit and the pattern byte aligned to
// this position, and registers whether this position agrees with the pattern.
// ----------------------------------------------------------------------------
module epc_cell
  import epc_pkg::*;
#(
  parameter int MAX_PATTERN = 32,
  parameter int IDX         = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  epc_cell_ctl_t                     ctl,
  input  logic [$clog2(MAX_PATTERN+1)-1:0]  m,
  input  logic [PIDX_W-1:0]                 ld_idx,
  input  logic [BYTE_W-1:0]                 ld_byte,
  input  logic [BYTE_W-1:0]                 win_in,
  input  logic                              vld_in,
  input  logic [BYTE_W-1:0]                 pat_in,
  output logic [BYTE_W-1:0]                 win_out,
  output logic                              vld_out,
  output logic [BYTE_W-1:0]                 pat_out,
  output logic                              ok
);

  localparam logic IS_HEAD = (IDX == 0);

  logic [BYTE_W-1:0] win_r;
  logic [BYTE_W-1:0] pat_r;
  logic              vld_r;
  logic              ok_r;
  logic              ok_nxt;
  logic              wr_here;

  // This cell holds pattern byte m-1-IDX.
  assign wr_here = ((int'(ld_idx) + IDX) == (int'(m) - 1));

  // Positions at or beyond the pattern length always agree.
  assign ok_nxt = (IDX >= int'(m)) || (vld_r && (win_r == pat_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.shift_txt) begin
      vld_r <= vld_in & (~ctl.clr | IS_HEAD);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift_txt) begin
      win_r <= win_in;
    end
    if (ctl.shift_pat) begin
      pat_r <= pat_in;
    end else if (ctl.ld && wr_here) begin
      pat_r <= ld_byte;
    end
    if (ctl.cap) begin
      ok_r <= ok_nxt;
    end
  end

  assign win_out = win_r;
  assign vld_out = vld_r;
  assign pat_out = pat_r;
  assign ok      = ok_r;

endmodule

// ===== rtl/epc_pattern_bank.sv =====
// ----------------------------------------------------------------------------
// epc_pattern_bank: pattern bytes in load order
// One write port for load items and one registered read port that feeds the
// realignment of the compare chain after a length change.
// ----------------------------------------------------------------------------
module epc_pattern_bank
  import epc_pkg::*;
#(
  parameter int MAX_PATTERN = 32
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [$clog2(MAX_PATTERN)-1:0]    wr_idx,
  input  logic [BYTE_W-1:0]                 wr_data,
  input  logic [$clog2(MAX_PATTERN)-1:0]    rd_idx,
  output logic [BYTE_W-1:0]                 rd_data
);

  logic [BYTE_W-1:0] mem_r [MAX_PATTERN];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_idx] <= wr_data;
    end
    rd_data_r <= mem_r[rd_idx];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/exact_pattern_occurrence_counter.sv =====
// ----------------------------------------------------------------------------
// exact_pattern_occurrence_counter: counts pattern occurrences in a text
// Load items write pattern bytes, text items shift through a chain of compare
// cells, and each text item returns its match flag and running count.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_item) takes load items and text
//   items; only text items give a result on the output channel (out_valid,
//   out_stall, out_item). One item is taken every cycle while in_stall is low.
//   A text item's result passes the window cells, then the per-cell compare
//   flags, then the output register with the all-positions AND and the count.
//   A text item with last_text_byte set returns the final count; the window
//   fill and the count restart with the next text item. The pattern is kept.
//   The cfg channel writes the pattern length; cfg_ready is always high.
//   After a write the chain realigns its pattern bytes from the pattern bank,
//   one byte per cycle, and in_stall stays high until the realignment ends.
//   When the receiver stalls, the result waits in the output register, the
//   pipeline fills behind it and in_stall rises once no stage is free.
//   Reset empties the pipeline, the window and the count and sets the length
//   to 2; pattern bytes are undefined until loaded.
// ----------------------------------------------------------------------------
module exact_pattern_occurrence_counter
  import epc_pkg::*;
#(
  parameter int MAX_PATTERN = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  epc_in_t          in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output epc_out_t         out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data
);

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int IW = $clog2(MAX_PATTERN);

  function automatic logic [LW-1:0] clamp_len(input logic [LEN_W-1:0] v);
    int n;
    n = int'(v);
    if (n < LEN_MIN) n = LEN_MIN;
    if (n > MAX_PATTERN) n = MAX_PATTERN;
    return LW'(n);
  endfunction

  epc_state_t         state_r, state_nxt;
  logic [LW-1:0]      m_r;
  logic [LW-1:0]      k_r, k_nxt;
  logic               rd_en;
  logic               rd_vld_r;
  logic               busy;

  logic               s1_vld_r, s1_last_r;
  logic               s2_vld_r, s2_last_r;
  logic               out_vld_r;
  epc_out_t           out_r;
  logic [COUNT_W-1:0] cnt_r;
  logic [COUNT_W-1:0] cnt_new;
  logic               clr_r;

  logic               in_acc, text_acc, load_acc, cfg_acc;
  logic               out_blk, s2_adv, s1_adv;
  logic               hit;
  logic               bank_we;
  logic [BYTE_W-1:0]  bank_rd;
  epc_cell_ctl_t      ctl;

  logic [BYTE_W-1:0]      win_chain [MAX_PATTERN+1];
  logic [BYTE_W-1:0]      pat_chain [MAX_PATTERN+1];
  logic                   vld_chain [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0] ok_vec;

  // Handshakes and pipeline advance
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;
  assign busy      = (state_r == ST_ALIGN);

  assign out_blk  = out_vld_r & out_stall;
  assign s2_adv   = s2_vld_r & ~out_blk;
  assign s1_adv   = s1_vld_r & (~s2_vld_r | s2_adv);
  assign in_stall = busy | (s1_vld_r & ~s1_adv);

  assign in_acc   = in_valid & ~in_stall;
  assign text_acc = in_acc & (in_item.cmd == CMD_TEXT);
  assign load_acc = in_acc & (in_item.cmd == CMD_LOAD);
  assign bank_we  = load_acc & (int'(in_item.pattern_index) < MAX_PATTERN);

  assign ctl.shift_txt = text_acc;
  assign ctl.clr       = clr_r;
  assign ctl.shift_pat = rd_vld_r;
  assign ctl.ld        = load_acc;
  assign ctl.cap       = s1_adv;

  // Realignment sequencer: after a length write, pattern bytes 0..m-1 are
  // shifted into the chain head so that cell i ends up with byte m-1-i.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      k_r      <= '0;
      rd_vld_r <= 1'b0;
      m_r      <= LW'(LEN_RESET);
    end else begin
      state_r  <= state_nxt;
      k_r      <= k_nxt;
      rd_vld_r <= rd_en;
      if (cfg_acc) begin
        m_r <= clamp_len(cfg_data);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        rd_en = 1'b0;
      end
      ST_ALIGN: begin
        rd_en = (k_r < m_r);
        if (rd_en) begin
          k_nxt = k_r + LW'(1);
        end else if (!rd_vld_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cfg_acc) begin
      state_nxt = ST_ALIGN;
      k_nxt     = '0;
      rd_en     = 1'b0;
    end
  end

  epc_pattern_bank #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_bank (
    .clk     (clk),
    .we      (bank_we),
    .wr_idx  (IW'(in_item.pattern_index)),
    .wr_data (in_item.byte_value),
    .rd_idx  (k_r[IW-1:0]),
    .rd_data (bank_rd)
  );

  // Compare chain
  assign win_chain[0] = in_item.byte_value;
  assign vld_chain[0] = 1'b1;
  assign pat_chain[0] = bank_rd;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    epc_cell #(
      .MAX_PATTERN(MAX_PATTERN),
      .IDX        (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .m       (m_r),
      .ld_idx  (in_item.pattern_index),
      .ld_byte (in_item.byte_value),
      .win_in  (win_chain[i]),
      .vld_in  (vld_chain[i]),
      .pat_in  (pat_chain[i]),
      .win_out (win_chain[i+1]),
      .vld_out (vld_chain[i+1]),
      .pat_out (pat_chain[i+1]),
      .ok      (ok_vec[i])
    );
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      clr_r     <= 1'b0;
      cnt_r     <= '0;
    end else begin
      if (text_acc) begin
        s1_vld_r <= 1'b1;
        clr_r    <= in_item.last_text_byte;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_vld_r <= 1'b1;
      end else if (s2_adv) begin
        s2_vld_r <= 1'b0;
      end
      if (s2_adv) begin
        out_vld_r <= 1'b1;
        cnt_r     <= s2_last_r ? '0 : cnt_new;
      end else if (out_vld_r && !out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign hit     = &ok_vec;
  assign cnt_new = (hit && (cnt_r != '1)) ? cnt_r + COUNT_W'(1) : cnt_r;

  always_ff @(posedge clk) begin
    if (text_acc) begin
      s1_last_r <= in_item.last_text_byte;
    end
    if (s1_adv) begin
      s2_last_r <= s1_last_r;
    end
    if (s2_adv) begin
      out_r.match_here  <= hit;
      out_r.match_count <= cnt_new;
      out_r.final_count <= s2_last_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

endmodule

// ===== rtl/epc_checker.sv =====
// ----------------------------------------------------------------------------
// epc_checker: port-level checks of the pattern occurrence counter
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module epc_checker
  import epc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_stall,
  input epc_out_t         out_item
);

  // A stalled result stays offered.
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result does not change.
  a_out_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_item))
    else $error("result changed while stalled");

  // A match always leaves a nonzero count.
  a_match_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.match_here |-> out_item.match_count != '0)
    else $error("match reported with zero count");

  // Reset empties the result stage.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind exact_pattern_occurrence_counter epc_checker u_epc_checker (.*);
